// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rotator rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_AFTER(label, clk, rst, pre, n, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> ##(n) (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, pre, post)
`define ASSERT_AFTER(label, clk, rst, pre, n, post)
`endif
`endif

// ----- rtl/qpr_pkg.sv -----
// shared types and constants for the quaternion point rotator
// no dependencies
package qpr_pkg;

  localparam int COORD_BITS    = 9;
  localparam int FRACTION_BITS = 16;
  localparam int CFG_BITS      = 18;
  localparam int CFG_FRAC      = 16;
  localparam int COLOR_BITS    = 24;

  localparam int POS_W     = COORD_BITS + FRACTION_BITS + 1;
  localparam int OUT_W     = COORD_BITS + 1;
  localparam int WORD_W    = 3 * COORD_BITS;
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);

  localparam int NUM_CELLS   = 3;
  localparam int CELL_STAGES = 5;
  localparam int LATENCY     = 3 + NUM_CELLS * CELL_STAGES;

  typedef logic signed [CFG_BITS-1:0] cfg_t;
  typedef logic signed [POS_W-1:0]    pos_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_X,
    REG_SIN_X,
    REG_COS_Y,
    REG_SIN_Y,
    REG_COS_Z,
    REG_SIN_Z
  } cfg_reg_t;

  localparam cfg_t CFG_ONE = cfg_t'(2 ** CFG_FRAC);
  localparam cfg_t CFG_RESET [NUM_REGS] = '{CFG_ONE, '0, CFG_ONE, '0, CFG_ONE, '0};

  // cell order: about y, then x, then z
  localparam cfg_reg_t COS_REG [NUM_CELLS] = '{REG_COS_Y, REG_COS_X, REG_COS_Z};
  localparam cfg_reg_t SIN_REG [NUM_CELLS] = '{REG_SIN_Y, REG_SIN_X, REG_SIN_Z};

  localparam pos_t POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam pos_t POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef struct packed {
    logic                  valid;
    logic [COLOR_BITS-1:0] color;
  } tag_t;

  typedef struct packed {
    tag_t tag;
    pos_t axis;
    pos_t p1;
    pos_t p2;
  } spin_t;

endpackage

// ----- rtl/qpr_cell.sv -----
// one rotation cell: quaternion sandwich about a single axis, five stages
// depends on qpr_pkg
module qpr_cell (
  input  logic           clk,
  input  logic           rst,
  input  qpr_pkg::cfg_t  cos_half,
  input  qpr_pkg::cfg_t  sin_half,
  input  qpr_pkg::spin_t in_pt,
  output qpr_pkg::spin_t out_pt
);
  import qpr_pkg::*;

  localparam int SQ_W       = 2 * CFG_BITS;
  localparam int COEF_W     = SQ_W + 1;
  localparam int COEF_FRAC  = 2 * CFG_FRAC;
  localparam int COEF_SPLIT = CFG_BITS;
  localparam int KL_W       = COEF_SPLIT + 1;
  localparam int PP_W       = POS_W + KL_W;
  localparam int HS_W       = PP_W + 1;
  localparam int SUM_W      = HS_W + COEF_SPLIT;
  localparam int RND_W      = SUM_W - COEF_FRAC;

  typedef logic signed [SQ_W-1:0]   sq_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [KL_W-1:0]   kpart_t;
  typedef logic signed [PP_W-1:0]   pp_t;
  typedef logic signed [HS_W-1:0]   hs_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [RND_W-1:0]  rnd_t;

  localparam sum_t HALF    = sum_t'(1) <<< (COEF_FRAC - 1);
  localparam rnd_t RND_MAX = rnd_t'(POS_MAX);
  localparam rnd_t RND_MIN = rnd_t'(POS_MIN);

  function automatic kpart_t hi_part(coef_t k);
    return kpart_t'($signed(k[COEF_W-1:COEF_SPLIT]));
  endfunction

  function automatic kpart_t lo_part(coef_t k);
    return kpart_t'({1'b0, k[COEF_SPLIT-1:0]});
  endfunction

  function automatic pp_t mul(pos_t v, kpart_t k);
    return pp_t'(v) * pp_t'(k);
  endfunction

  // valid bit cleared while in reset
  function automatic tag_t gate_tag(tag_t t, logic clr);
    return '{valid: t.valid & ~clr, color: t.color};
  endfunction

  // round half away from zero, then clamp to the coordinate range
  function automatic pos_t round_sat(sum_t s);
    sum_t t;
    rnd_t r;
    t = s + (s[SUM_W-1] ? HALF - sum_t'(1) : HALF);
    r = rnd_t'(t >>> COEF_FRAC);
    if (r < RND_MIN) begin
      return POS_MIN;
    end else if (r > RND_MAX) begin
      return POS_MAX;
    end
    return pos_t'(r);
  endfunction

  sq_t   cc, ss, cs;
  coef_t a, b, g;

  spin_t st0, st4;
  tag_t  t1, t2, t3;
  pp_t   a1h, a1l, b2h, b2l, a2h, a2l, b1h, b1l, gh, gl;
  hs_t   h1, l1, h2, l2, hg, lg;
  sum_t  s1, s2, sg;

  // coefficients follow the config registers
  always_ff @(posedge clk) begin
    cc <= sq_t'(cos_half) * sq_t'(cos_half);
    ss <= sq_t'(sin_half) * sq_t'(sin_half);
    cs <= sq_t'(cos_half) * sq_t'(sin_half);
    a  <= coef_t'(cc) - coef_t'(ss);
    b  <= coef_t'(cs) <<< 1;
    g  <= coef_t'(cc) + coef_t'(ss);
  end

  always_ff @(posedge clk) begin
    st0.tag  <= gate_tag(in_pt.tag, rst);
    st0.axis <= in_pt.axis;
    st0.p1   <= in_pt.p1;
    st0.p2   <= in_pt.p2;

    t1  <= gate_tag(st0.tag, rst);
    a1h <= mul(st0.p1, hi_part(a));
    a1l <= mul(st0.p1, lo_part(a));
    b2h <= mul(st0.p2, hi_part(b));
    b2l <= mul(st0.p2, lo_part(b));
    a2h <= mul(st0.p2, hi_part(a));
    a2l <= mul(st0.p2, lo_part(a));
    b1h <= mul(st0.p1, hi_part(b));
    b1l <= mul(st0.p1, lo_part(b));
    gh  <= mul(st0.axis, hi_part(g));
    gl  <= mul(st0.axis, lo_part(g));

    t2 <= gate_tag(t1, rst);
    h1 <= hs_t'(a1h) - hs_t'(b2h);
    l1 <= hs_t'(a1l) - hs_t'(b2l);
    h2 <= hs_t'(a2h) + hs_t'(b1h);
    l2 <= hs_t'(a2l) + hs_t'(b1l);
    hg <= hs_t'(gh);
    lg <= hs_t'(gl);

    t3 <= gate_tag(t2, rst);
    s1 <= (sum_t'(h1) <<< COEF_SPLIT) + sum_t'(l1);
    s2 <= (sum_t'(h2) <<< COEF_SPLIT) + sum_t'(l2);
    sg <= (sum_t'(hg) <<< COEF_SPLIT) + sum_t'(lg);

    st4.tag  <= gate_tag(t3, rst);
    st4.p1   <= round_sat(s1);
    st4.p2   <= round_sat(s2);
    st4.axis <= round_sat(sg);
  end

  assign out_pt = st4;

endmodule

// ----- rtl/quaternion_point_rotator.sv -----
// top level of the quaternion point rotator: config registers, unpack,
// a row of three rotation cells and the integer output stage
// depends on qpr_pkg, qpr_cell and assert_macros.svh

// Takes one point transaction per clock whenever busy is low; busy is high
// only during reset and the cycle after it. Every transaction returns its
// result as a one-cycle done strobe after it passes capture, unpack, three
// rotation cells (y, then x, then z) of five stages each, and the output
// register. The receiver cannot stall, so done must be taken in the cycle it
// is shown. Each cell derives its rotation coefficients from the config
// registers after a write, through its product registers and then its
// coefficient registers; a transaction started on or after the write edge already sees the new angle.
`include "assert_macros.svh"

module quaternion_point_rotator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [qpr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [qpr_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [qpr_pkg::WORD_W-1:0]           position_word,
  input  logic [qpr_pkg::COLOR_BITS-1:0]       color,
  output logic                                 done,
  output logic signed [qpr_pkg::OUT_W-1:0]     rotated_x,
  output logic signed [qpr_pkg::OUT_W-1:0]     rotated_y,
  output logic signed [qpr_pkg::OUT_W-1:0]     rotated_z,
  output logic                                 front_facing,
  output logic [qpr_pkg::COLOR_BITS-1:0]       color_out
);
  import qpr_pkg::*;

  localparam int FW   = POS_W + 1;
  localparam int RI_W = FW - FRACTION_BITS;

  typedef logic signed [FW-1:0]    fx_t;
  typedef logic signed [RI_W-1:0]  rint_t;
  typedef logic signed [OUT_W-1:0] out_t;

  localparam fx_t  HALF_F  = fx_t'(1) <<< (FRACTION_BITS - 1);
  localparam out_t OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam out_t OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  function automatic pos_t unpack(logic [COORD_BITS-1:0] c);
    return pos_t'($signed(c)) <<< FRACTION_BITS;
  endfunction

  function automatic out_t to_int(pos_t v);
    fx_t   t;
    rint_t r;
    t = fx_t'(v) + (v[POS_W-1] ? HALF_F - fx_t'(1) : HALF_F);
    r = $signed(t[FW-1:FRACTION_BITS]);
    if (r < rint_t'(OUT_MIN)) begin
      return OUT_MIN;
    end else if (r > rint_t'(OUT_MAX)) begin
      return OUT_MAX;
    end
    return out_t'(r);
  endfunction

  cfg_t cfg_r [NUM_REGS];
  logic live;
  logic accept;

  logic                  raw_valid;
  logic [WORD_W-1:0]     raw_word;
  logic [COLOR_BITS-1:0] raw_color;

  spin_t unp;
  spin_t link [NUM_CELLS+1];
  out_t  rz;

  assign busy   = rst | ~live;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      live  <= 1'b0;
      cfg_r <= CFG_RESET;
    end else begin
      live <= 1'b1;
      if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
        cfg_r[cfg_index] <= cfg_data;
      end
    end
  end

  // capture, then unpack; the cells see (axis, p1, p2) = (z, x, y) here
  always_ff @(posedge clk) begin
    raw_word      <= position_word;
    raw_color     <= color;
    unp.tag.color <= raw_color;
    unp.axis      <= unpack(raw_word[COORD_BITS-1:0]);
    unp.p1        <= unpack(raw_word[WORD_W-1:2*COORD_BITS]);
    unp.p2        <= unpack(raw_word[2*COORD_BITS-1:COORD_BITS]);
    if (rst) begin
      raw_valid     <= 1'b0;
      unp.tag.valid <= 1'b0;
    end else begin
      raw_valid     <= accept;
      unp.tag.valid <= raw_valid;
    end
  end

  assign link[0] = unp;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    spin_t cin;
    // rotate axis order so each cell turns about the next axis
    assign cin.tag  = link[k].tag;
    assign cin.axis = link[k].p2;
    assign cin.p1   = link[k].axis;
    assign cin.p2   = link[k].p1;

    qpr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cos_half (cfg_r[COS_REG[k]]),
      .sin_half (cfg_r[SIN_REG[k]]),
      .in_pt    (cin),
      .out_pt   (link[k+1])
    );
  end

  // after the z cell: axis = z, p1 = x, p2 = y
  assign rz = to_int(link[NUM_CELLS].axis);

  always_ff @(posedge clk) begin
    rotated_x    <= to_int(link[NUM_CELLS].p1);
    rotated_y    <= to_int(link[NUM_CELLS].p2);
    rotated_z    <= rz;
    front_facing <= ~rz[OUT_W-1];
    color_out    <= link[NUM_CELLS].tag.color;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= link[NUM_CELLS].tag.valid;
    end
  end

  `ASSERT_AFTER(a_fixed_latency, clk, rst, start && !busy, LATENCY, done)
  `ASSERT_IMPLY(a_done_has_source, clk, rst, done, $past(start && !busy, LATENCY))

endmodule
